// File: design/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared types and constants for the weather frame decoder.
// ----------------------------------------------------------------------------
package wfd_pkg;

    localparam int FRAME_BYTES_DEF = 23;

    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 12;
    localparam int RAIN_W   = 16;
    localparam int TEMP_W   = 17;
    localparam int HUM_W    = 8;
    localparam int WAVG_W   = 5;
    localparam int GUST_W   = 8;
    localparam int DIR_W    = 9;
    localparam int STATUS_W = 3;

    // result beat: status, temperature, humidity, wind avg/gust/dir, rain total, rain hour
    localparam int RESULT_W   = STATUS_W + TEMP_W + HUM_W + WAVG_W + GUST_W + DIR_W
                                + RAIN_W + RAIN_W;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd2700;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // frame layout
    localparam int IDX_HDR1      = 1;
    localparam int IDX_HDR2      = 2;
    localparam int IDX_TEMP_HI   = 6;
    localparam int IDX_TEMP_LO   = 7;
    localparam int IDX_HUM       = 8;
    localparam int IDX_WAVG      = 10;
    localparam int IDX_GUST      = 11;
    localparam int IDX_DIR_HI    = 12;
    localparam int IDX_DIR_LO    = 13;
    localparam int IDX_RAIN_HI   = 14;
    localparam int IDX_RAIN_LO   = 15;
    localparam int IDX_SUM_FIRST = 1;
    localparam int IDX_SUM_LAST  = 19;
    localparam int IDX_CHECK     = 20;

    localparam logic [BYTE_W-1:0] HDR1_VAL = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR2_VAL = 8'h00;

    localparam logic [15:0]       TEMP_OFFSET = 16'd500;
    localparam logic [15:0]       TEMP_MAX    = 16'd400;
    localparam logic [BYTE_W-1:0] HUM_MAX     = 8'd100;

    // x*10/85 == (x*964) >> 13 for x < 256 (964 = 2 * ceil(2^13/17))
    localparam int WAVG_PROD_W = 18;
    localparam logic [WAVG_PROD_W-1:0] WAVG_MUL = 18'd964;
    localparam int WAVG_SHIFT = 13;
    // x*73/100 == (x*765478) >> 20 for x < 256 (765478 = 73 * ceil(2^20/100))
    localparam int GUST_PROD_W = 28;
    localparam logic [GUST_PROD_W-1:0] GUST_MUL = 28'd765478;
    localparam int GUST_SHIFT = 20;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_SUM    = 3'd2,
        ST_TEMP_HIGH  = 3'd3,
        ST_HUM_HIGH   = 3'd4
    } status_t;

    // frame bytes the decoder looks at, plus the running checksum
    typedef struct packed {
        logic [BYTE_W-1:0] hdr1;
        logic [BYTE_W-1:0] hdr2;
        logic [BYTE_W-1:0] temp_hi;
        logic [BYTE_W-1:0] temp_lo;
        logic [BYTE_W-1:0] hum;
        logic [BYTE_W-1:0] wavg;
        logic [BYTE_W-1:0] gust;
        logic [BYTE_W-1:0] dir_hi;
        logic [BYTE_W-1:0] dir_lo;
        logic [BYTE_W-1:0] rain_hi;
        logic [BYTE_W-1:0] rain_lo;
        logic [BYTE_W-1:0] check;
        logic [BYTE_W-1:0] sum;
    } frame_bytes_t;

    typedef struct packed {
        status_t                  status;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic [WAVG_W-1:0]        wind_average;
        logic [GUST_W-1:0]        wind_gust;
        logic [DIR_W-1:0]         wind_direction;
        logic [RAIN_W-1:0]        rain_total;
    } decode_t;

endpackage

// File: design/wfd_assembler.sv
// ----------------------------------------------------------------------------
// wfd_assembler
// Frame byte store, byte position and running checksum of bytes 1..19.
// ----------------------------------------------------------------------------
module wfd_assembler #(
    parameter int FRAME_BYTES = wfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_en,
    input  logic [wfd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        frame_start,
    output logic                        frame_done,
    output wfd_pkg::frame_bytes_t       frame
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = $clog2(FRAME_BYTES);

    logic [wfd_pkg::BYTE_W-1:0] store_reg [FRAME_BYTES];
    logic [wfd_pkg::BYTE_W-1:0] view      [FRAME_BYTES];
    logic [POS_W-1:0]           pos_reg, pos_next, pos_eff;
    logic [wfd_pkg::BYTE_W-1:0] sum_reg, sum_next;
    logic                       wr;

    always_comb begin
        pos_eff    = frame_start ? '0 : pos_reg;
        wr         = byte_en && (pos_eff < POS_W'(FRAME_BYTES));
        pos_next   = wr ? pos_eff + POS_W'(1) : pos_eff;
        if (!byte_en) begin
            pos_next = pos_reg;
        end
        frame_done = wr && (pos_eff == POS_W'(FRAME_BYTES - 1));

        sum_next = sum_reg;
        if (wr) begin
            if (pos_eff == '0) begin
                sum_next = '0;
            end else if (pos_eff <= POS_W'(wfd_pkg::IDX_SUM_LAST)) begin
                sum_next = sum_reg + data_byte;
            end
        end
    end

    // current byte forwarded so the last byte can be decoded in its own cycle
    for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_view
        assign view[i] = (wr && pos_eff[IDX_W-1:0] == IDX_W'(i)) ? data_byte : store_reg[i];
    end

    always_comb begin
        frame.hdr1    = view[wfd_pkg::IDX_HDR1];
        frame.hdr2    = view[wfd_pkg::IDX_HDR2];
        frame.temp_hi = view[wfd_pkg::IDX_TEMP_HI];
        frame.temp_lo = view[wfd_pkg::IDX_TEMP_LO];
        frame.hum     = view[wfd_pkg::IDX_HUM];
        frame.wavg    = view[wfd_pkg::IDX_WAVG];
        frame.gust    = view[wfd_pkg::IDX_GUST];
        frame.dir_hi  = view[wfd_pkg::IDX_DIR_HI];
        frame.dir_lo  = view[wfd_pkg::IDX_DIR_LO];
        frame.rain_hi = view[wfd_pkg::IDX_RAIN_HI];
        frame.rain_lo = view[wfd_pkg::IDX_RAIN_LO];
        frame.check   = view[wfd_pkg::IDX_CHECK];
        frame.sum     = sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            store_reg[pos_eff[IDX_W-1:0]] <= data_byte;
        end
        sum_reg <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_W'(FRAME_BYTES);
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: design/wfd_decode.sv
// ----------------------------------------------------------------------------
// wfd_decode
// Frame checks and field scaling for one completed frame.
// ----------------------------------------------------------------------------
module wfd_decode (
    input  wfd_pkg::frame_bytes_t frame,
    output wfd_pkg::decode_t      dec
);

    logic [15:0]                        temp_raw;
    logic [wfd_pkg::WAVG_PROD_W-1:0]    wavg_prod;
    logic [wfd_pkg::GUST_PROD_W-1:0]    gust_prod;
    wfd_pkg::status_t                   status;

    always_comb begin
        temp_raw  = {frame.temp_hi, frame.temp_lo};
        wavg_prod = wfd_pkg::WAVG_PROD_W'(frame.wavg) * wfd_pkg::WAVG_MUL;
        gust_prod = wfd_pkg::GUST_PROD_W'(frame.gust) * wfd_pkg::GUST_MUL;

        if (frame.hdr1 != wfd_pkg::HDR1_VAL || frame.hdr2 != wfd_pkg::HDR2_VAL) begin
            status = wfd_pkg::ST_BAD_HEADER;
        end else if (frame.sum != frame.check) begin
            status = wfd_pkg::ST_BAD_SUM;
        end else if (temp_raw > wfd_pkg::TEMP_OFFSET + wfd_pkg::TEMP_MAX) begin
            status = wfd_pkg::ST_TEMP_HIGH;
        end else if (frame.hum > wfd_pkg::HUM_MAX) begin
            status = wfd_pkg::ST_HUM_HIGH;
        end else begin
            status = wfd_pkg::ST_OK;
        end

        dec        = '0;
        dec.status = status;
        if (status == wfd_pkg::ST_OK) begin
            dec.temperature    = {1'b0, temp_raw} - {1'b0, wfd_pkg::TEMP_OFFSET};
            dec.humidity       = frame.hum;
            dec.wind_average   = wavg_prod[wfd_pkg::WAVG_SHIFT +: wfd_pkg::WAVG_W];
            dec.wind_gust      = gust_prod[wfd_pkg::GUST_SHIFT +: wfd_pkg::GUST_W];
            dec.wind_direction = {frame.dir_hi[1], frame.dir_lo};
            dec.rain_total     = {frame.rain_hi, frame.rain_lo};
        end
    end

endmodule

// File: design/wfd_rain.sv
// ----------------------------------------------------------------------------
// wfd_rain
// Rain baseline alignment, tick counter and hourly rain tracking.
// ----------------------------------------------------------------------------
module wfd_rain (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_en,
    input  logic                          frame_ok_en,
    input  logic [wfd_pkg::RAIN_W-1:0]    rain_total,
    input  logic [wfd_pkg::PERIOD_W-1:0]  period,
    output logic [wfd_pkg::RAIN_W-1:0]    hourly_rain_next
);

    logic                          aligned_reg,  aligned_next;
    logic [wfd_pkg::RAIN_W-1:0]    baseline_reg, baseline_next;
    logic [wfd_pkg::RAIN_W-1:0]    counter_reg,  counter_next;
    logic [wfd_pkg::RAIN_W-1:0]    hourly_reg;
    logic [wfd_pkg::PERIOD_W-1:0]  tick_reg,     tick_next;
    logic [wfd_pkg::PERIOD_W:0]    tick_inc;
    logic [wfd_pkg::RAIN_W-1:0]    rise;

    always_comb begin
        aligned_next     = aligned_reg;
        baseline_next    = baseline_reg;
        counter_next     = counter_reg;
        hourly_rain_next = hourly_reg;
        tick_next        = tick_reg;
        tick_inc         = {1'b0, tick_reg} + 1'b1;
        rise             = counter_reg - baseline_reg;

        // ticks count only once the baseline is aligned
        if (tick_en && aligned_reg) begin
            if (tick_inc >= {1'b0, period}) begin
                tick_next     = '0;
                baseline_next = counter_reg;
                if (rise != '0) begin
                    hourly_rain_next = rise;
                end
            end else begin
                tick_next = tick_inc[wfd_pkg::PERIOD_W-1:0];
            end
        end

        if (frame_ok_en) begin
            counter_next = rain_total;
            if (!aligned_reg) begin
                baseline_next    = rain_total;
                hourly_rain_next = '0;
                aligned_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aligned_reg  <= 1'b0;
            baseline_reg <= '0;
            counter_reg  <= '0;
            hourly_reg   <= '0;
            tick_reg     <= '0;
        end else begin
            aligned_reg  <= aligned_next;
            baseline_reg <= baseline_next;
            counter_reg  <= counter_next;
            hourly_reg   <= hourly_rain_next;
            tick_reg     <= tick_next;
        end
    end

endmodule

// File: design/weather_frame_decoder.sv
// ----------------------------------------------------------------------------
// weather_frame_decoder
// Decodes weather-station radio frames byte by byte and tracks hourly rain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one beat per frame byte or per timer tick. tuser[0]
//   selects the kind (0 byte, 1 tick), tuser[1] marks frame byte zero, tdata
//   holds the byte. Ticks drive the hourly rain period once the first valid
//   frame has aligned the rain baseline.
//   Master stream carries one result beat per completed frame: status,
//   decoded fields and the current hourly rain.
//   cfg_wr_en / cfg_wr_data write rain_period_ticks; write only while idle.
// Timing:
//   One beat per cycle sustained while the result register is free or being
//   drained. A beat lands in the input register and is processed once the
//   result register is free or being drained; a frame's result is clocked
//   into the output register at the end of the cycle that processes its last
//   byte, and m_axis_tvalid is driven from that register.
// Stall:
//   While a result waits on m_axis_tready the input register still takes one
//   beat; further beats are held off by s_axis_tready.
// Reset:
//   aresetn low clears both registers' valids and rain state, sets the
//   byte position to FRAME_BYTES (idle, no frame) and period to 2700 ticks.
// ----------------------------------------------------------------------------
module weather_frame_decoder #(
    parameter int FRAME_BYTES = wfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [wfd_pkg::PERIOD_W-1:0]     cfg_wr_data,   // rain_period_ticks

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wfd_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  logic [wfd_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // [0] req_type, [1] frame_start

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [19:3] temperature, [27:20] humidity, [32:28] wind_average,
    // [40:33] wind_gust, [49:41] wind_direction, [65:50] rain_total,
    // [81:66] rain_hour, rest zero
    output logic [wfd_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    // configuration
    logic [wfd_pkg::PERIOD_W-1:0]  period_reg;

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic [wfd_pkg::S_TDATA_W-1:0] in_data_reg;
    logic [wfd_pkg::S_TUSER_W-1:0] in_user_reg;

    // result register
    logic                          out_valid_reg, out_valid_next;
    wfd_pkg::decode_t              out_dec_reg;
    logic [wfd_pkg::RAIN_W-1:0]    out_hour_reg;

    logic                          s_accept;
    logic                          proc_fire;
    logic                          byte_en, tick_en;
    logic                          frame_done;
    wfd_pkg::frame_bytes_t         frame;
    wfd_pkg::decode_t              dec;
    logic [wfd_pkg::RAIN_W-1:0]    hourly_rain_next;

    // stage advances whenever it holds a beat and the result register is free or being drained
    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign byte_en = proc_fire && (in_user_reg[0] == wfd_pkg::REQ_BYTE);
    assign tick_en = proc_fire && (in_user_reg[0] == wfd_pkg::REQ_TICK);

    wfd_assembler #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_assembler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_en     (byte_en),
        .data_byte   (in_data_reg[wfd_pkg::BYTE_W-1:0]),
        .frame_start (in_user_reg[1]),
        .frame_done  (frame_done),
        .frame       (frame)
    );

    wfd_decode u_decode (
        .frame (frame),
        .dec   (dec)
    );

    wfd_rain u_rain (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick_en          (tick_en),
        .frame_ok_en      (frame_done && dec.status == wfd_pkg::ST_OK),
        .rain_total       (dec.rain_total),
        .period           (period_reg),
        .hourly_rain_next (hourly_rain_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc_fire && frame_done) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= wfd_pkg::PERIOD_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
        if (proc_fire && frame_done) begin
            out_dec_reg  <= dec;
            out_hour_reg <= hourly_rain_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (wfd_pkg::M_TDATA_W - wfd_pkg::RESULT_W)'(0),
        out_hour_reg,
        out_dec_reg.rain_total,
        out_dec_reg.wind_direction,
        out_dec_reg.wind_gust,
        out_dec_reg.wind_average,
        out_dec_reg.humidity,
        out_dec_reg.temperature,
        out_dec_reg.status
    };

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !proc_fire)
        else $error("input stage advanced over a held result");

    a_result_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_user_reg[0] == wfd_pkg::REQ_BYTE))
        else $error("result raised without a frame byte");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_dec_reg.status != wfd_pkg::ST_OK |->
        out_dec_reg.temperature == '0 && out_dec_reg.humidity == '0 &&
        out_dec_reg.wind_average == '0 && out_dec_reg.wind_gust == '0 &&
        out_dec_reg.wind_direction == '0 && out_dec_reg.rain_total == '0)
        else $error("rejected frame carries decoded fields");

    a_ok_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_dec_reg.status == wfd_pkg::ST_OK |->
        out_dec_reg.temperature <= 17'sd400 &&
        out_dec_reg.humidity <= wfd_pkg::HUM_MAX)
        else $error("accepted frame out of range");

endmodule
